// ===== hdl/debounced_tooth_tachometer_macros.svh =====
// Assertion macros for the debounced tooth tachometer.
// Used by the top level; needs clock and reset in the including scope.
`ifndef DEBOUNCED_TOOTH_TACHOMETER_MACROS_SVH
`define DEBOUNCED_TOOTH_TACHOMETER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define DTT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define DTT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/dtt_pkg.sv =====
// Shared types and constants for the debounced tooth tachometer.
// No dependencies.
`default_nettype none

package dtt_pkg;

   localparam int unsigned TIME_W     = 32;
   localparam int unsigned DEBOUNCE_W = 20;
   localparam int unsigned TEETH_W    = 8;
   localparam int unsigned SPEED_W    = 26;
   localparam int unsigned DEN_W      = TIME_W + TEETH_W;
   localparam int unsigned QUOT_W     = SPEED_W;
   localparam int unsigned STEP_W     = 5;
   localparam int unsigned CSR_IDX_W  = 2;

   localparam logic [STEP_W-1:0]     DIV_STEPS     = STEP_W'(QUOT_W);
   localparam logic [SPEED_W-1:0]    RPM_NUMERATOR = 26'd60000000;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST  = 20'd1000;
   localparam logic [TEETH_W-1:0]    TEETH_RST     = 8'd36;

   localparam logic OP_PULSE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEETH    = 2'd1;

   typedef struct packed {
      logic              operation;
      logic [TIME_W-1:0] time_us;
   } req_type;

   typedef struct packed {
      logic               pulse_accepted;
      logic [TEETH_W-1:0] tooth_index;
      logic [SPEED_W-1:0] speed_rpm;
      logic               speed_updated;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_FIN
   } seq_state_type;

endpackage

`default_nettype wire

// ===== hdl/debounced_tooth_tachometer.sv =====
// Usage: req_* carries one event per beat (operation 0 = sensor pulse with its
// microsecond timestamp, 1 = speed query); rsp_* returns one result beat per
// event with the debounce verdict, tooth counter, held speed and update flag.
// csr_* writes debounce_us (index 0) and tooth_count (index 1); always ready,
// write only while the block is idle.
// Every event passes a check state and a finish state. In between, accepted
// pulses and queries with a pending interval run 26 iterations of a shared
// restoring divider (speed = 60000000 / (interval * teeth), or the tooth
// counter wrap as a remainder); rejected pulses and queries with nothing
// pending skip the divider. A new event is taken only once the previous one
// has been handed to the output register.
// req_stall is high while an event is in work. A stalled result holds in the
// output register; a following event then waits in its finish cycle.
// Reset (synchronous, active high) restores debounce 1000 us, 36 teeth and
// clears timestamp, pending interval, tooth counter and speed.
// Depends on dtt_pkg and debounced_tooth_tachometer_macros.svh.
`default_nettype none

`include "debounced_tooth_tachometer_macros.svh"

module debounced_tooth_tachometer (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output      logic                                   req_stall,
   input  wire dtt_pkg::req_type                       req_data,
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   output      dtt_pkg::rsp_type                       rsp_data,
   input  wire logic                                   csr_valid,
   output      logic                                   csr_ready,
   input  wire logic [dtt_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [dtt_pkg::DEBOUNCE_W-1:0]         csr_wdata
);

   dtt_pkg::seq_state_type state_ff, state_in;

   logic [dtt_pkg::DEBOUNCE_W-1:0] debounce_ff;
   logic [dtt_pkg::TEETH_W-1:0]    teeth_ff;
   logic [dtt_pkg::TIME_W-1:0]     last_stamp_ff, last_stamp_in;
   logic [dtt_pkg::TIME_W-1:0]     pending_ff, pending_in;
   logic [dtt_pkg::TEETH_W-1:0]    counter_ff, counter_in;
   logic [dtt_pkg::SPEED_W-1:0]    speed_ff, speed_in;

   logic                           op_ff;
   logic [dtt_pkg::TIME_W-1:0]     time_ff;
   logic                           do_div_ff, do_div_in;

   logic [dtt_pkg::QUOT_W-1:0]     quot_ff, quot_in;
   logic [dtt_pkg::DEN_W-1:0]      rem_ff, rem_in;
   logic [dtt_pkg::DEN_W-1:0]      den_ff, den_in;
   logic [dtt_pkg::STEP_W-1:0]     step_ff, step_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   dtt_pkg::rsp_type               rsp_ff, rsp_in;

   logic                           req_take;
   logic                           out_free;
   logic [dtt_pkg::TEETH_W-1:0]    teeth_eff;
   logic [dtt_pkg::TIME_W-1:0]     diff;
   logic                           debounce_ok;
   logic [dtt_pkg::DEN_W:0]        shifted;
   logic [dtt_pkg::DEN_W:0]        trial;
   logic                           fits;
   logic                           finish;
   logic                           is_pulse;

   assign req_stall = (state_ff != dtt_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_pulse  = (op_ff == dtt_pkg::OP_PULSE);

   assign teeth_eff   = (teeth_ff == '0) ? dtt_pkg::TEETH_W'(1) : teeth_ff;
   assign diff        = time_ff - last_stamp_ff;
   assign debounce_ok = (diff >= dtt_pkg::TIME_W'(debounce_ff));

   // one restoring division step
   assign shifted = {rem_ff, quot_ff[dtt_pkg::QUOT_W-1]};
   assign trial   = shifted - {1'b0, den_ff};
   assign fits    = (shifted >= {1'b0, den_ff});
   assign finish  = (state_ff == dtt_pkg::ST_FIN) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dtt_pkg::ST_IDLE: begin
            if (req_take) state_in = dtt_pkg::ST_CHECK;
         end
         dtt_pkg::ST_CHECK: begin
            if (is_pulse) state_in = debounce_ok ? dtt_pkg::ST_DIV : dtt_pkg::ST_FIN;
            else          state_in = (pending_ff != '0) ? dtt_pkg::ST_DIV : dtt_pkg::ST_FIN;
         end
         dtt_pkg::ST_DIV: begin
            if (step_ff == dtt_pkg::DIV_STEPS - dtt_pkg::STEP_W'(1)) state_in = dtt_pkg::ST_FIN;
         end
         dtt_pkg::ST_FIN: begin
            if (out_free) state_in = dtt_pkg::ST_IDLE;
         end
         default: state_in = dtt_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      last_stamp_in = last_stamp_ff;
      pending_in    = pending_ff;
      counter_in    = counter_ff;
      speed_in      = speed_ff;
      do_div_in     = do_div_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      step_in       = step_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         dtt_pkg::ST_IDLE: begin
            step_in = '0;
         end
         dtt_pkg::ST_CHECK: begin
            rem_in = '0;
            if (is_pulse) begin
               do_div_in = debounce_ok;
               quot_in   = dtt_pkg::QUOT_W'({1'b0, counter_ff} + 9'd1);
               den_in    = dtt_pkg::DEN_W'(teeth_eff);
               if (debounce_ok) begin
                  pending_in    = diff;
                  last_stamp_in = time_ff;
               end
            end else begin
               do_div_in = (pending_ff != '0);
               quot_in   = dtt_pkg::RPM_NUMERATOR;
               den_in    = dtt_pkg::DEN_W'(pending_ff) * dtt_pkg::DEN_W'(teeth_eff);
            end
         end
         dtt_pkg::ST_DIV: begin
            rem_in  = fits ? trial[dtt_pkg::DEN_W-1:0] : shifted[dtt_pkg::DEN_W-1:0];
            quot_in = {quot_ff[dtt_pkg::QUOT_W-2:0], fits};
            step_in = step_ff + dtt_pkg::STEP_W'(1);
         end
         dtt_pkg::ST_FIN: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.pulse_accepted = is_pulse && do_div_ff;
               rsp_in.speed_updated  = !is_pulse && do_div_ff;
               if (do_div_ff && is_pulse) counter_in = rem_ff[dtt_pkg::TEETH_W-1:0];
               if (do_div_ff && !is_pulse) begin
                  speed_in   = quot_ff;
                  pending_in = '0;
               end
               rsp_in.tooth_index = (do_div_ff && is_pulse) ?
                                    rem_ff[dtt_pkg::TEETH_W-1:0] : counter_ff;
               rsp_in.speed_rpm   = (do_div_ff && !is_pulse) ? quot_ff : speed_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dtt_pkg::ST_IDLE;
         debounce_ff   <= dtt_pkg::DEBOUNCE_RST;
         teeth_ff      <= dtt_pkg::TEETH_RST;
         last_stamp_ff <= '0;
         pending_ff    <= '0;
         counter_ff    <= '0;
         speed_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         do_div_ff     <= 1'b0;
         step_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         last_stamp_ff <= last_stamp_in;
         pending_ff    <= pending_in;
         counter_ff    <= counter_in;
         speed_ff      <= speed_in;
         rsp_valid_ff  <= rsp_valid_in;
         do_div_ff     <= do_div_in;
         step_ff       <= step_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               dtt_pkg::CSR_DEBOUNCE: debounce_ff <= csr_wdata;
               dtt_pkg::CSR_TEETH:    teeth_ff    <= csr_wdata[dtt_pkg::TEETH_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff   <= req_data.operation;
         time_ff <= req_data.time_us;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      rsp_ff  <= rsp_in;
   end

   `DTT_ASSERT_SAME(a_div_bound, (state_ff == dtt_pkg::ST_DIV), (step_ff < dtt_pkg::DIV_STEPS), "divider step out of range")
   `DTT_ASSERT_SAME(a_rem_below, (state_ff == dtt_pkg::ST_DIV), (rem_ff < den_ff), "partial remainder not below divisor")
   `DTT_ASSERT_SAME(a_flags_excl, rsp_valid_ff, !(rsp_ff.pulse_accepted && rsp_ff.speed_updated), "pulse and speed flags both set")
   `DTT_ASSERT_NEXT(a_fin_loads, finish, rsp_valid_ff, "finished event not presented")

endmodule

`default_nettype wire

// ===== verif/debounced_tooth_tachometer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for debounced_tooth_tachometer: directed and random
// pulse/query beats, register phases, scoreboard predicting every result beat.
// Depends on dtt_pkg and the debounced_tooth_tachometer RTL.

module debounced_tooth_tachometer_tb;

   localparam logic [dtt_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd2;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_EVENTS  = 125;
   localparam int CALM_EVENTS   = 150;
   localparam int DRAIN_CYCLES  = 40;

   class tach_scoreboard;
      logic [dtt_pkg::DEBOUNCE_W-1:0] debounce;
      logic [dtt_pkg::TEETH_W-1:0]    teeth;
      logic [dtt_pkg::TIME_W-1:0]     last_stamp;
      logic [dtt_pkg::TIME_W-1:0]     interval;
      logic [dtt_pkg::TEETH_W-1:0]    tooth;
      logic [dtt_pkg::SPEED_W-1:0]    speed;
      dtt_pkg::rsp_type               expected_q[$];
      int                             errors;

      function new();
         debounce   = dtt_pkg::DEBOUNCE_RST;
         teeth      = dtt_pkg::TEETH_RST;
         last_stamp = '0;
         interval   = '0;
         tooth      = '0;
         speed      = '0;
         errors     = 0;
      endfunction

      function void write_register(logic [dtt_pkg::CSR_IDX_W-1:0] idx,
                                   logic [dtt_pkg::DEBOUNCE_W-1:0] data);
         if (idx == dtt_pkg::CSR_DEBOUNCE) begin
            debounce = data;
         end else if (idx == dtt_pkg::CSR_TEETH) begin
            teeth = data[dtt_pkg::TEETH_W-1:0];
         end
      endfunction

      function void note_event(dtt_pkg::req_type ev);
         dtt_pkg::rsp_type             r;
         logic [dtt_pkg::TIME_W-1:0]   diff;
         logic [dtt_pkg::TEETH_W-1:0]  eff;
         logic [dtt_pkg::DEN_W-1:0]    den;
         eff = (teeth == '0) ? dtt_pkg::TEETH_W'(1) : teeth;
         r = '0;
         if (ev.operation == dtt_pkg::OP_PULSE) begin
            diff = ev.time_us - last_stamp;
            if (diff >= dtt_pkg::TIME_W'(debounce)) begin
               interval   = diff;
               last_stamp = ev.time_us;
               tooth      = dtt_pkg::TEETH_W'((9'(tooth) + 9'd1) % 9'(eff));
               r.pulse_accepted = 1'b1;
            end
         end else if (interval != '0) begin
            den      = dtt_pkg::DEN_W'(interval) * dtt_pkg::DEN_W'(eff);
            speed    = dtt_pkg::SPEED_W'(dtt_pkg::DEN_W'(dtt_pkg::RPM_NUMERATOR) / den);
            interval = '0;
            r.speed_updated = 1'b1;
         end
         r.tooth_index = tooth;
         r.speed_rpm   = speed;
         expected_q.push_back(r);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_result(dtt_pkg::rsp_type got);
         dtt_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            report("result beat with nothing expected");
         end else begin
            want = expected_q.pop_front();
            if (got.pulse_accepted !== want.pulse_accepted)
               report($sformatf("pulse_accepted got %0d want %0d",
                                got.pulse_accepted, want.pulse_accepted));
            if (got.tooth_index !== want.tooth_index)
               report($sformatf("tooth_index got %0d want %0d",
                                got.tooth_index, want.tooth_index));
            if (got.speed_rpm !== want.speed_rpm)
               report($sformatf("speed_rpm got %0d want %0d",
                                got.speed_rpm, want.speed_rpm));
            if (got.speed_updated !== want.speed_updated)
               report($sformatf("speed_updated got %0d want %0d",
                                got.speed_updated, want.speed_updated));
         end
      endtask
   endclass

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   dtt_pkg::req_type               req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   dtt_pkg::rsp_type               rsp_data;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [dtt_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [dtt_pkg::DEBOUNCE_W-1:0] csr_wdata = '0;

   tach_scoreboard                 board = new();
   logic                           quiet = 1'b0;
   logic [dtt_pkg::TIME_W-1:0]     timeline = '0;
   int                             stall_run = 0;

   debounced_tooth_tachometer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (stall_run == 0 && !quiet && $urandom_range(0, 9) == 0)
         stall_run = $urandom_range(1, 19);
      rsp_stall <= (stall_run != 0);
      if (stall_run != 0)
         stall_run = stall_run - 1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_data);
   end

   task automatic send_event(logic op, logic [dtt_pkg::TIME_W-1:0] stamp);
      int               gap;
      dtt_pkg::req_type ev;
      ev.operation = op;
      ev.time_us   = stamp;
      gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      do @(posedge clock); while (req_stall);
      board.note_event(ev);
   endtask

   task automatic write_reg(logic [dtt_pkg::CSR_IDX_W-1:0] idx,
                            logic [dtt_pkg::DEBOUNCE_W-1:0] data);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_register(idx, data);
      csr_valid <= 1'b0;
   endtask

   // queries and mostly debounce-clean pulses; some early pulses, jumps and wild stamps
   task automatic random_events(int count);
      int pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            send_event(dtt_pkg::OP_QUERY, $urandom());
         end else begin
            if (pick < 70)
               timeline = timeline + board.debounce + $urandom_range(0, 3000);
            else if (pick < 85)
               timeline = timeline + $urandom_range(0, board.debounce);
            else if (pick < 93)
               timeline = timeline + $urandom();
            else
               timeline = $urandom();
            send_event(dtt_pkg::OP_PULSE, timeline);
         end
      end
   endtask

   initial begin
      #1_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      logic [dtt_pkg::DEBOUNCE_W-1:0] teeth_word;
      logic [dtt_pkg::DEBOUNCE_W-1:0] deb_plan [RANDOM_PHASES];
      logic [dtt_pkg::TEETH_W-1:0]    teeth_plan [RANDOM_PHASES];
      deb_plan   = '{20'd1000, 20'd0, 20'hFFFFF, 20'd1000000, 20'd200, 20'd25, 20'd0, 20'd0};
      teeth_plan = '{8'd36, 8'd0, 8'd255, 8'd1, 8'd7, 8'd2, 8'd0, 8'd0};
      deb_plan[6]   = dtt_pkg::DEBOUNCE_W'($urandom_range(0, 5000));
      deb_plan[7]   = dtt_pkg::DEBOUNCE_W'($urandom_range(0, 300));
      teeth_plan[6] = dtt_pkg::TEETH_W'($urandom_range(0, 255));
      teeth_plan[7] = dtt_pkg::TEETH_W'($urandom_range(1, 255));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: debounce edge, wrap of the timestamp, held speed
      send_event(dtt_pkg::OP_QUERY, $urandom());
      send_event(dtt_pkg::OP_PULSE, 32'd0);
      send_event(dtt_pkg::OP_PULSE, 32'd999);
      send_event(dtt_pkg::OP_PULSE, 32'd1000);
      send_event(dtt_pkg::OP_QUERY, $urandom());
      send_event(dtt_pkg::OP_QUERY, $urandom());
      send_event(dtt_pkg::OP_PULSE, 32'd1999);
      send_event(dtt_pkg::OP_PULSE, 32'hFFFF_FFFF);
      send_event(dtt_pkg::OP_QUERY, $urandom());
      send_event(dtt_pkg::OP_PULSE, 32'd998);
      send_event(dtt_pkg::OP_PULSE, 32'd999);
      send_event(dtt_pkg::OP_QUERY, $urandom());

      // zero debounce, zero teeth: zero interval, then the fastest speed
      write_reg(dtt_pkg::CSR_DEBOUNCE, '0);
      write_reg(dtt_pkg::CSR_TEETH, '0);
      send_event(dtt_pkg::OP_PULSE, 32'd999);
      send_event(dtt_pkg::OP_QUERY, $urandom());
      send_event(dtt_pkg::OP_PULSE, 32'd1000);
      send_event(dtt_pkg::OP_QUERY, $urandom());

      // largest debounce and tooth count, then counter not below a lowered count
      write_reg(dtt_pkg::CSR_DEBOUNCE, '1);
      write_reg(dtt_pkg::CSR_TEETH, '1);
      send_event(dtt_pkg::OP_PULSE, 32'd1000 + 32'd1048574);
      send_event(dtt_pkg::OP_PULSE, 32'd1000 + 32'd1048575);
      send_event(dtt_pkg::OP_PULSE, 32'd1000 + 32'd2097150);
      send_event(dtt_pkg::OP_QUERY, $urandom());
      write_reg(dtt_pkg::CSR_TEETH, 20'd2);
      send_event(dtt_pkg::OP_PULSE, 32'd1000 + 32'd3145725);
      write_reg(CSR_SPARE, dtt_pkg::DEBOUNCE_W'($urandom()));
      send_event(dtt_pkg::OP_QUERY, $urandom());
      timeline = 32'd1000 + 32'd3145725;

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         quiet = (ph == 3);
         teeth_word = dtt_pkg::DEBOUNCE_W'($urandom());
         teeth_word[dtt_pkg::TEETH_W-1:0] = teeth_plan[ph];
         write_reg(dtt_pkg::CSR_DEBOUNCE, deb_plan[ph]);
         write_reg(dtt_pkg::CSR_TEETH, teeth_word);
         random_events(PHASE_EVENTS);
      end
      quiet = 1'b1;
      random_events(CALM_EVENTS);
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
